// ----- rtl/core/pfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the page frame allocator: widths, function codes, directory
// entry layout, sequencer states and the control structs shared by all files.
// No dependencies.
package pfa_pkg;

    localparam int PFA_FRAMES            = 32;
    localparam int PFA_DIR_ENTRIES       = 1024;
    localparam int PFA_KERNEL_FIRST_PAGE = 768;

    localparam int ADDR_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int PAGE_SHIFT = 22;
    localparam int IDX_W      = $clog2(PFA_DIR_ENTRIES);
    localparam int FRAME_W    = 10;
    localparam int FREE_W     = 6;
    localparam int NEED_W     = ADDR_W - PAGE_SHIFT + 1;

    // Bits of the frame bitmap examined by the search unit in one cycle.
    localparam int SCAN_W = 16;
    localparam int POS_W  = $clog2(SCAN_W);

    localparam logic [IDX_W-1:0] KERNEL_SLOT = IDX_W'(10'h300);
    localparam logic [IDX_W-1:0] DIR_LAST    = IDX_W'(PFA_DIR_ENTRIES - 1);

    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MAP   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_QUERY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CHECK = 3'd4;

    typedef struct packed {
        logic               present;
        logic               write;
        logic               user;
        logic [FRAME_W-1:0] frame;
    } t_dir_entry;

    localparam int ENTRY_W = $bits(t_dir_entry);

    localparam t_dir_entry KERNEL_ENTRY = '{present: 1'b1, write: 1'b1, user: 1'b0,
                                            frame: '0};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_dir_entry       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_dir_ctl;

    typedef struct packed {
        logic               set_en;
        logic               clr_en;
        logic [FRAME_W-1:0] idx;
    } t_map_ctl;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
    } t_scan_res;

endpackage

// ----- rtl/core/pfa_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces of the page frame allocator.
// Depends on pfa_pkg.
interface pfa_req_if import pfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] map_addr;
    logic [ADDR_W-1:0] amount;

    modport source (output valid, func, virt_addr, map_addr, amount, input ready);
    modport sink   (input valid, func, virt_addr, map_addr, amount, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [FRAME_W-1:0] frame;
    logic [FREE_W-1:0]  free_frames;

    modport source (output valid, ok, frame, free_frames, input ready);
    modport sink   (input valid, ok, frame, free_frames, output ready);
endinterface

// ----- rtl/core/pfa_dir_ram.sv -----
`timescale 1ns / 1ps
// Page directory storage: one write port and one read port with registered
// read data. Depends on pfa_pkg.
module pfa_dir_ram import pfa_pkg::*; (
    input  logic       i_clk,
    input  t_dir_ctl   i_ctl,
    output t_dir_entry o_rdata
);

    t_dir_entry r_mem [PFA_DIR_ENTRIES];
    t_dir_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pfa_frame_map.sv -----
`timescale 1ns / 1ps
// Frame bitmap with the search unit that looks for a free frame in one slice
// of the bitmap per cycle. Depends on pfa_pkg.
module pfa_frame_map import pfa_pkg::*; #(
    parameter  int FRAMES  = PFA_FRAMES,
    localparam int NCHUNK  = (FRAMES + SCAN_W - 1) / SCAN_W,
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_map_ctl             i_ctl,
    input  logic [CHUNK_W-1:0]   i_chunk,
    output t_scan_res            o_scan
);

    localparam int FIDX_W  = $clog2(FRAMES);

    logic [FRAMES-1:0]        r_used;
    logic [NCHUNK*SCAN_W-1:0] w_pad;
    logic [SCAN_W-1:0]        w_bits;
    logic                     w_found;
    logic [POS_W-1:0]         w_pos;

    // Frame 0 is never handed out, so its bit stays set from reset on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= {{(FRAMES-1){1'b0}}, 1'b1};
        end else begin
            if (i_ctl.set_en) begin
                r_used[i_ctl.idx[FIDX_W-1:0]] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_used[i_ctl.idx[FIDX_W-1:0]] <= 1'b0;
            end
        end
    end

    // Bits past the last frame read as used so the search never lands there.
    always_comb begin
        w_pad             = '1;
        w_pad[FRAMES-1:0] = r_used;
        w_bits            = w_pad[i_chunk*SCAN_W +: SCAN_W];
        w_found           = 1'b0;
        w_pos             = '0;
        for (int k = SCAN_W - 1; k >= 0; k--) begin
            if (!w_bits[k]) begin
                w_found = 1'b1;
                w_pos   = POS_W'(k);
            end
        end
    end

    assign o_scan.found = w_found;
    assign o_scan.frame = FRAME_W'({i_chunk, w_pos});

endmodule

// ----- rtl/core/page_frame_allocator_with_directory.sv -----
`timescale 1ns / 1ps
// Page frame allocator with a single 1024-entry page directory: top level
// with the sequencer. Depends on pfa_pkg, pfa_if, pfa_dir_ram, pfa_frame_map.
//
// Usage: a request item on i_req carries func, virt_addr, map_addr and
// amount; bits 31:22 of virt_addr pick the directory entry. Every request
// gives exactly one response item on o_rsp with ok, frame and free_frames.
// Functions are allocate, free, map, query present and capacity check.
//
// Flow: an accepted item goes through the directory read, evaluate (S_LOOK)
// and the load of the output register (S_DONE) for free, map, query and
// check; allocate may also walk the frame bitmap (S_SCAN), 16 frames per
// cycle in the search unit, before S_DONE. The block handles one item at a
// time; i_req.ready is high only while the sequencer is idle, so a new item
// is taken only after the last one has left S_DONE.
//
// Reset: after i_rst_n is released the sequencer sweeps the directory, one
// entry per cycle; requests are not accepted meanwhile. The bitmap and the
// free count return to their reset values at once.
//
// Stall: the response sits in an output register; a new request is taken
// while it waits, but the next response is held back until it is taken.
module page_frame_allocator_with_directory import pfa_pkg::*; #(
    parameter int FRAMES            = PFA_FRAMES,
    parameter int KERNEL_FIRST_PAGE = PFA_KERNEL_FIRST_PAGE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_req_if.sink   i_req,
    pfa_rsp_if.source o_rsp
);

    localparam int NCHUNK  = (FRAMES + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FCNT_W  = $clog2(FRAMES + 1);
    localparam int CMP_W   = FCNT_W + NEED_W;

    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NCHUNK - 1);
    localparam logic [FCNT_W-1:0]  FRAMES_CNT = FCNT_W'(FRAMES);
    localparam logic [IDX_W-1:0]   KFP_IDX    = IDX_W'(KERNEL_FIRST_PAGE);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_clr_idx, n_clr_idx;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [FCNT_W-1:0]   r_count, n_count;
    logic                r_out_valid, n_out_valid;

    logic [FUNC_W-1:0]   r_func, n_func;
    logic [ADDR_W-1:0]   r_va, n_va;
    logic [ADDR_W-1:0]   r_pa, n_pa;
    logic [ADDR_W-1:0]   r_amount, n_amount;
    logic                r_res_ok, n_res_ok;
    logic [FRAME_W-1:0]  r_res_frame, n_res_frame;
    logic                r_out_ok, n_out_ok;
    logic [FRAME_W-1:0]  r_out_frame, n_out_frame;
    logic [FREE_W-1:0]   r_out_free, n_out_free;

    t_dir_ctl            w_dir_ctl;
    t_dir_entry          w_ent;
    t_map_ctl            w_map_ctl;
    t_scan_res           w_scan;

    logic [IDX_W-1:0]    w_idx;
    logic                w_kernel;
    logic                w_bad_frame;
    logic [NEED_W-1:0]   w_need;
    logic [FCNT_W+FREE_W-1:0] w_free_ext;

    pfa_dir_ram u_dir (
        .i_clk   (i_clk),
        .i_ctl   (w_dir_ctl),
        .o_rdata (w_ent)
    );

    pfa_frame_map #(
        .FRAMES (FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_map_ctl),
        .i_chunk (r_chunk),
        .o_scan  (w_scan)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_chunk     <= '0;
            r_count     <= FCNT_W'(FRAMES - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_va        <= n_va;
        r_pa        <= n_pa;
        r_amount    <= n_amount;
        r_res_ok    <= n_res_ok;
        r_res_frame <= n_res_frame;
        r_out_ok    <= n_out_ok;
        r_out_frame <= n_out_frame;
        r_out_free  <= n_out_free;
    end

    assign w_idx       = r_va[PAGE_SHIFT +: IDX_W];
    assign w_kernel    = (w_idx >= KFP_IDX);
    assign w_bad_frame = (w_ent.frame == '0) ||
                         ({1'b0, w_ent.frame} >= (FRAME_W + 1)'(FRAMES));
    // Whole frames needed, rounded up; cannot wrap at this width.
    assign w_need      = {1'b0, r_amount[ADDR_W-1:PAGE_SHIFT]} +
                         NEED_W'(|r_amount[PAGE_SHIFT-1:0]);
    assign w_free_ext  = {{FREE_W{1'b0}}, r_count};

    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_chunk     = r_chunk;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_func      = r_func;
        n_va        = r_va;
        n_pa        = r_pa;
        n_amount    = r_amount;
        n_res_ok    = r_res_ok;
        n_res_frame = r_res_frame;
        n_out_ok    = r_out_ok;
        n_out_frame = r_out_frame;
        n_out_free  = r_out_free;

        w_dir_ctl       = '0;
        w_dir_ctl.waddr = w_idx;
        w_dir_ctl.raddr = i_req.virt_addr[PAGE_SHIFT +: IDX_W];
        w_map_ctl       = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_dir_ctl.we    = 1'b1;
                w_dir_ctl.waddr = r_clr_idx;
                w_dir_ctl.wdata = (r_clr_idx == KERNEL_SLOT) ? KERNEL_ENTRY : '0;
                n_clr_idx       = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == DIR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    w_dir_ctl.re = 1'b1;
                    n_func       = i_req.func;
                    n_va         = i_req.virt_addr;
                    n_pa         = i_req.map_addr;
                    n_amount     = i_req.amount;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res_ok    = 1'b0;
                n_res_frame = '0;
                n_chunk     = '0;
                n_state     = S_DONE;
                unique case (r_func)
                    FN_ALLOC: begin
                        if (!w_kernel && !w_ent.present) begin
                            n_state = S_SCAN;
                        end
                    end
                    FN_FREE: begin
                        if (!w_kernel && w_ent.present && !w_bad_frame) begin
                            w_map_ctl.clr_en = 1'b1;
                            w_map_ctl.idx    = w_ent.frame;
                            w_dir_ctl.we     = 1'b1;
                            w_dir_ctl.wdata  = '0;
                            if (r_count < FRAMES_CNT) begin
                                n_count = r_count + FCNT_W'(1);
                            end
                            n_res_ok    = 1'b1;
                            n_res_frame = w_ent.frame;
                        end
                    end
                    FN_MAP: begin
                        if (!w_kernel && (r_pa[PAGE_SHIFT-1:0] == '0)) begin
                            // Address zero is accepted but leaves the directory alone.
                            w_dir_ctl.we    = (r_va != '0);
                            w_dir_ctl.wdata = '{present: 1'b1, write: 1'b1, user: 1'b1,
                                                frame: r_pa[PAGE_SHIFT +: FRAME_W]};
                            n_res_ok        = 1'b1;
                        end
                    end
                    FN_QUERY: begin
                        n_res_ok = (r_va != '0) && w_ent.present;
                    end
                    FN_CHECK: begin
                        n_res_ok = ({{NEED_W{1'b0}}, r_count} >= CMP_W'(w_need));
                    end
                    default: begin
                        n_res_ok = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_scan.found) begin
                    w_map_ctl.set_en = 1'b1;
                    w_map_ctl.idx    = w_scan.frame;
                    w_dir_ctl.we     = 1'b1;
                    w_dir_ctl.wdata  = '{present: 1'b1, write: 1'b1, user: 1'b1,
                                         frame: w_scan.frame};
                    if (r_count != '0) begin
                        n_count = r_count - FCNT_W'(1);
                    end
                    n_res_ok    = 1'b1;
                    n_res_frame = w_scan.frame;
                    n_state     = S_DONE;
                end else if (r_chunk == LAST_CHUNK) begin
                    n_state = S_DONE;
                end else begin
                    n_chunk = r_chunk + CHUNK_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_frame = r_res_frame;
                    n_out_free  = w_free_ext[FREE_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.frame       = r_out_frame;
    assign o_rsp.free_frames = r_out_free;

endmodule

// ----- rtl/core/pfa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the page frame allocator and its bind statement.
// Depends on pfa_pkg and page_frame_allocator_with_directory.
module pfa_checker import pfa_pkg::*; #(
    parameter int FRAMES = PFA_FRAMES
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_rsp_ok,
    input logic [FRAME_W-1:0] i_rsp_frame,
    input logic [FREE_W-1:0]  i_rsp_free
);

    // Reset empties the output and starts the directory sweep.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid && !i_req_ready)
        else $error("response or ready seen right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_ok) &&
            $stable(i_rsp_frame) && $stable(i_rsp_free))
        else $error("stalled response item changed");

    a_fail_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> i_rsp_frame == '0)
        else $error("failed item reports a frame");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_frame != '0) |-> i_rsp_ok && (i_rsp_frame < FRAMES))
        else $error("reported frame out of range");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_free <= FRAMES)
        else $error("free count above frame total");

endmodule

bind page_frame_allocator_with_directory pfa_checker #(
    .FRAMES (FRAMES)
) u_pfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.ok),
    .i_rsp_frame (o_rsp.frame),
    .i_rsp_free  (o_rsp.free_frames)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for page_frame_allocator_with_directory: a shadow copy of
// the frame bitmap and directory predicts every response item on o_rsp.
// Depends on pfa_pkg, pfa_if and the allocator RTL.
module testbench;
    import pfa_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_PERCENT = 18;
    localparam int          TAIL_CYCLES  = 12;
    localparam int          VA_POOL_LAST = 63;
    localparam logic [31:0] FRAME_BYTES  = 32'h0040_0000;
    localparam logic [FUNC_W-1:0] FN_RESERVED = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] map_addr;
        logic [ADDR_W-1:0] amount;
    } t_page_req;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
        logic [FREE_W-1:0]  free_frames;
    } t_page_rsp;

    logic clk;
    logic rst_n;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    page_frame_allocator_with_directory dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow copy of the allocator state.
    bit          frame_busy [PFA_FRAMES];
    int unsigned free_cnt;
    t_dir_entry  dir_shadow [PFA_DIR_ENTRIES];

    t_page_rsp awaited_rsps[$];

    bit calm;
    int hold_req;
    int hold_seen;
    int failures;
    int cycle_cnt;
    int rsps_checked;
    int ops_sent [8];
    int alloc_no_frame;
    int stale_frees;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_page_req page_req(input logic [FUNC_W-1:0] func,
                                           input logic [ADDR_W-1:0] va,
                                           input logic [ADDR_W-1:0] pa,
                                           input logic [ADDR_W-1:0] amount);
        return '{func: func, virt_addr: va, map_addr: pa, amount: amount};
    endfunction

    // Applies one request to the shadow state and returns the response it owes.
    function automatic t_page_rsp apply_page_op(input t_page_req r);
        logic [IDX_W-1:0] slot;
        t_dir_entry       ent;
        t_page_rsp        rsp;
        int unsigned      need;
        int               f;
        slot = r.virt_addr[PAGE_SHIFT +: IDX_W];
        ent  = dir_shadow[slot];
        rsp  = '0;
        case (r.func)
            FN_ALLOC: begin
                if (slot < PFA_KERNEL_FIRST_PAGE && !ent.present) begin
                    f = 1;
                    while (f < PFA_FRAMES && frame_busy[f]) f++;
                    if (f < PFA_FRAMES) begin
                        frame_busy[f] = 1'b1;
                        if (free_cnt > 0) free_cnt--;
                        dir_shadow[slot] = '{present: 1'b1, write: 1'b1, user: 1'b1,
                                             frame: FRAME_W'(f)};
                        rsp.ok    = 1'b1;
                        rsp.frame = FRAME_W'(f);
                    end else begin
                        alloc_no_frame++;
                    end
                end
            end
            FN_FREE: begin
                if (slot < PFA_KERNEL_FIRST_PAGE && ent.present && ent.frame != '0 &&
                    ent.frame < PFA_FRAMES) begin
                    // A frame installed by map may never have been taken from the
                    // bitmap; the count still rises, up to its ceiling.
                    if (!frame_busy[ent.frame]) stale_frees++;
                    frame_busy[ent.frame] = 1'b0;
                    if (free_cnt < PFA_FRAMES) free_cnt++;
                    dir_shadow[slot] = '0;
                    rsp.ok    = 1'b1;
                    rsp.frame = ent.frame;
                end
            end
            FN_MAP: begin
                if (slot < PFA_KERNEL_FIRST_PAGE && r.map_addr[PAGE_SHIFT-1:0] == '0) begin
                    if (r.virt_addr != '0) begin
                        dir_shadow[slot] = '{present: 1'b1, write: 1'b1, user: 1'b1,
                                             frame: r.map_addr[PAGE_SHIFT +: FRAME_W]};
                    end
                    rsp.ok = 1'b1;
                end
            end
            FN_QUERY: begin
                rsp.ok = (r.virt_addr != '0) && ent.present;
            end
            FN_CHECK: begin
                need = (r.amount >> PAGE_SHIFT) + (r.amount[PAGE_SHIFT-1:0] != '0);
                rsp.ok = (free_cnt >= need);
            end
            default: begin
            end
        endcase
        rsp.free_frames = free_cnt[FREE_W-1:0];
        return rsp;
    endfunction

    // Weights are percentages; whatever is left over goes to unused function codes.
    function automatic t_page_req random_page_req(input int w_alloc, input int w_free,
                                                  input int w_map, input int w_query,
                                                  input int w_check);
        t_page_req   r;
        int          pick;
        int unsigned k;
        r.virt_addr = $urandom();
        r.map_addr  = $urandom();
        r.amount    = $urandom();
        pick = $urandom_range(99);
        if (pick < w_alloc)                                  r.func = FN_ALLOC;
        else if (pick < w_alloc + w_free)                    r.func = FN_FREE;
        else if (pick < w_alloc + w_free + w_map)            r.func = FN_MAP;
        else if (pick < w_alloc + w_free + w_map + w_query)  r.func = FN_QUERY;
        else if (pick < w_alloc + w_free + w_map + w_query + w_check) r.func = FN_CHECK;
        else r.func = FN_CHECK + FUNC_W'($urandom_range(1, 3));

        // Most addresses land in a small user pool so that entries get reused.
        pick = $urandom_range(99);
        if (pick < 70)
            r.virt_addr[PAGE_SHIFT +: IDX_W] = IDX_W'($urandom_range(0, VA_POOL_LAST));
        else if (pick < 82)
            r.virt_addr[PAGE_SHIFT +: IDX_W] = IDX_W'($urandom_range(PFA_KERNEL_FIRST_PAGE,
                                                                     PFA_DIR_ENTRIES - 1));
        else if (pick < 86)
            r.virt_addr = '0;

        pick = $urandom_range(99);
        if (pick < 60)
            r.map_addr = {FRAME_W'($urandom_range(0, PFA_FRAMES + 8)), 22'd0};
        else if (pick < 75)
            r.map_addr[PAGE_SHIFT-1:0] = '0;

        if ($urandom_range(99) < 65) begin
            k = $urandom_range(0, PFA_FRAMES + 2);
            r.amount = k * FRAME_BYTES + $urandom_range(0, 2) - 1;
        end
        return r;
    endfunction

    task automatic send_page_req(input t_page_req r);
        if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.func      <= r.func;
        req_ch.virt_addr <= r.virt_addr;
        req_ch.map_addr  <= r.map_addr;
        req_ch.amount    <= r.amount;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        awaited_rsps.push_back(apply_page_op(r));
        ops_sent[r.func]++;
    endtask

    task automatic send_random_items(input int n, input int w_alloc, input int w_free,
                                     input int w_map, input int w_query, input int w_check);
        repeat (n) send_page_req(random_page_req(w_alloc, w_free, w_map, w_query, w_check));
    endtask

    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsps.size() != 0) @(posedge clk);
    endtask

    task automatic test_corner_cases();
        send_page_req(page_req(FN_QUERY, 32'hC000_0000, '0, '0));
        send_page_req(page_req(FN_QUERY, 32'h0000_0000, '0, '0));
        send_page_req(page_req(FN_ALLOC, 32'h0040_0000, '0, '0));
        send_page_req(page_req(FN_ALLOC, 32'h0040_0000, '0, '0));
        send_page_req(page_req(FN_ALLOC, 32'hFFFF_FFFF, '0, '0));
        send_page_req(page_req(FN_FREE,  32'h0040_0000, '0, '0));
        send_page_req(page_req(FN_FREE,  32'h0040_0000, '0, '0));
        send_page_req(page_req(FN_FREE,  32'hC000_0000, '0, '0));
        // Map at address zero answers ok but must leave entry 0 untouched.
        send_page_req(page_req(FN_MAP,   32'h0000_0000, 32'h0080_0000, '0));
        send_page_req(page_req(FN_QUERY, 32'h0000_0123, '0, '0));
        send_page_req(page_req(FN_MAP,   32'h0080_0000, 32'h0080_0001, '0));
        send_page_req(page_req(FN_MAP,   32'h0080_0000, 32'h0080_0000, '0));
        // Frame 2 was never allocated, so this free pushes the count to its ceiling.
        send_page_req(page_req(FN_FREE,  32'h0080_0000, '0, '0));
        send_page_req(page_req(FN_MAP,   32'h00C0_0000, 32'hFFC0_0000, '0));
        send_page_req(page_req(FN_FREE,  32'h00C0_0000, '0, '0));
        send_page_req(page_req(FN_MAP,   32'h0100_0000, 32'h0000_0000, '0));
        send_page_req(page_req(FN_FREE,  32'h0100_0000, '0, '0));
        send_page_req(page_req(FN_MAP,   32'hC800_0000, 32'h0080_0000, '0));
        send_page_req(page_req(FN_CHECK, '0, '0, PFA_FRAMES * FRAME_BYTES));
        send_page_req(page_req(FN_CHECK, '0, '0, PFA_FRAMES * FRAME_BYTES + 1));
        send_page_req(page_req(FN_CHECK, '0, '0, 32'hFFFF_FFFF));
        send_page_req(page_req(FN_CHECK, '0, '0, 32'h0000_0000));
        send_page_req(page_req(FN_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        wait_for_responses();
    endtask

    task automatic test_random_traffic();
        send_random_items(500, 28, 24, 15, 15, 13);
        wait_for_responses();
    endtask

    task automatic test_exhaust_and_release();
        send_random_items(250, 70, 5, 5, 10, 10);
        send_random_items(200, 8, 62, 5, 10, 15);
        wait_for_responses();
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        send_random_items(250, 30, 25, 15, 15, 12);
        calm = 1'b0;
        wait_for_responses();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // output register fills and the block has to stall its request side.
    task automatic test_output_stall();
        hold_req++;
        send_random_items(40, 30, 25, 15, 15, 12);
        wait_for_responses();
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk) begin
        t_page_rsp want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsps.size() == 0) begin
                $error("response item with none outstanding: ok %0d frame %0d free %0d",
                       rsp_ch.ok, rsp_ch.frame, rsp_ch.free_frames);
                failures++;
            end else begin
                want = awaited_rsps.pop_front();
                rsps_checked++;
                if (rsp_ch.ok !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, rsp_ch.ok);
                    failures++;
                end
                if (rsp_ch.frame !== want.frame) begin
                    $error("frame: expected %0d, actual %0d", want.frame, rsp_ch.frame);
                    failures++;
                end
                if (rsp_ch.free_frames !== want.free_frames) begin
                    $error("free_frames: expected %0d, actual %0d",
                           want.free_frames, rsp_ch.free_frames);
                    failures++;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.func      <= FN_QUERY;
        req_ch.virt_addr <= '0;
        req_ch.map_addr  <= '0;
        req_ch.amount    <= '0;
        calm      = 1'b0;
        hold_req  = 0;
        hold_seen = 0;
        failures  = 0;
        for (int i = 0; i < PFA_FRAMES; i++) frame_busy[i] = (i == 0);
        for (int i = 0; i < PFA_DIR_ENTRIES; i++) dir_shadow[i] = '0;
        dir_shadow[KERNEL_SLOT] = KERNEL_ENTRY;
        free_cnt = PFA_FRAMES - 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_random_traffic();
        test_exhaust_and_release();
        test_back_to_back();
        test_output_stall();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent alloc %0d, free %0d, map %0d, query %0d, check %0d, unused codes %0d.",
                 ops_sent[FN_ALLOC], ops_sent[FN_FREE], ops_sent[FN_MAP], ops_sent[FN_QUERY],
                 ops_sent[FN_CHECK], ops_sent[5] + ops_sent[6] + ops_sent[7]);
        $display("Checked %0d responses; %0d allocations hit a full bitmap, %0d frees hit %s",
                 rsps_checked, alloc_no_frame, stale_frees, "an already free frame.");
        if (failures == 0 && awaited_rsps.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- page_frame_allocator_with_directory.f -----
rtl/core/pfa_pkg.sv
rtl/core/pfa_if.sv
rtl/core/pfa_dir_ram.sv
rtl/core/pfa_frame_map.sv
rtl/core/page_frame_allocator_with_directory.sv
rtl/core/pfa_checker.sv
bench/testbench.sv
